/* src/rpc_handle_table_assert.svh */
// Assertion helpers shared by the handle table modules.
// Each module that uses them has clk and rst in scope.
`ifndef RPC_HANDLE_TABLE_ASSERT_SVH
`define RPC_HANDLE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define RHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rht_pkg.sv */
`default_nettype none

package rht_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int NODE_W    = 8;
  localparam int SEQ_W     = 32;
  localparam int LOCAL_W   = 16;
  localparam int ENTRY_W   = NODE_W + SEQ_W;

  // The free-slot search splits the bitmap into groups of lanes.
  localparam int LANES   = 8;
  localparam int GROUPS  = NUM_SLOTS / LANES;
  localparam int LANE_W  = $clog2(LANES);
  localparam int GROUP_W = $clog2(GROUPS);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FIND  = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_OUT_OF_HNDL  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
  localparam logic [2:0] ST_INVALID_SLOT = 3'd3;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               use_given_id;
    logic               new_seq_wanted;
    logic [NODE_W-1:0]  id_node;
    logic [SEQ_W-1:0]   id_seq;
    logic [LOCAL_W-1:0] id_local;
    logic [LOCAL_W-1:0] free_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [NODE_W-1:0]  out_node;
    logic [SEQ_W-1:0]   out_seq;
    logic [LOCAL_W-1:0] out_local;
  } rsp_t;

  // Bitmap update: set or clear one used bit.
  typedef struct packed {
    logic              we;
    logic              set;
    logic [SLOT_W-1:0] idx;
  } map_upd_t;

  // Result of the lowest-free-slot search.
  typedef struct packed {
    logic              any_free;
    logic [SLOT_W-1:0] first_free;
  } map_stat_t;

endpackage

`default_nettype wire

/* src/rht_if.sv */
`default_nettype none

interface rht_req_if import rht_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rht_rsp_if import rht_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/rpc_handle_table.sv */
// RPC handle table: allocates, looks up and releases handle slots.
// Requests arrive on the req channel and each one produces exactly one
// result on the rsp channel, in order; both are valid/ready handshakes.
// The own node number is set through cfg_wr_en/cfg_wr_data and should be
// written only while no request is in flight.
// In the cycle a request is accepted the slot memory read is issued; once
// the request executes, the result is formed, the memory and bitmap are
// written back and the result register is loaded. The registered memory
// read sets this order, and a new request is accepted only after the last
// one has executed.
// The free-slot search runs on registered per-group results taken from the
// bitmap, which are always current by the time the next request executes.
// Reset clears the bitmap (every slot free), the sequence counter and the
// own node number; the slot memory is not cleared, since a slot's entry is
// only read while the slot is in use and therefore after it was written.
// If the receiver stalls, the finished result stays in the output register
// while one more request is accepted; that request then waits in its
// execute cycle until the output register has been emptied.

`default_nettype none
`include "rpc_handle_table_assert.svh"

module rpc_handle_table import rht_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [NODE_W-1:0] cfg_wr_data,
  rht_req_if.sink                req,
  rht_rsp_if.source              rsp
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state;
  logic [NODE_W-1:0] own_node;
  logic [SEQ_W-1:0]  seq_counter;
  logic [SEQ_W-1:0]  seq_next;
  logic              rsp_valid;
  rsp_t              rsp_data;
  rsp_t              rsp_next;
  req_t              cur;

  logic               accept;
  logic               exec_go;
  logic               ram_wr;
  logic [SLOT_W-1:0]  ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_data;
  map_upd_t           map_req;
  map_upd_t           upd;
  map_stat_t          stat;
  logic [NUM_SLOTS-1:0] used;

  logic              find_in_range;
  logic              free_in_range;
  logic [SLOT_W-1:0] find_idx;
  logic [SLOT_W-1:0] free_idx;
  logic [NODE_W-1:0] rd_node;
  logic [SEQ_W-1:0]  rd_seq;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign exec_go   = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Slot entries: node number in the upper bits, sequence number below.
  rht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_wr && exec_go),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .re      (accept),
    .rd_addr (req.data.id_local[SLOT_W-1:0]),
    .rd_data (ram_rd_data)
  );

  assign upd = '{we: map_req.we && exec_go, set: map_req.set, idx: map_req.idx};

  rht_map u_map (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .used (used),
    .stat (stat)
  );

  assign rd_node       = ram_rd_data[ENTRY_W-1 -: NODE_W];
  assign rd_seq        = ram_rd_data[SEQ_W-1:0];
  assign find_in_range = (cur.id_local < LOCAL_W'(NUM_SLOTS));
  assign free_in_range = (cur.free_slot < LOCAL_W'(NUM_SLOTS));
  assign find_idx      = cur.id_local[SLOT_W-1:0];
  assign free_idx      = cur.free_slot[SLOT_W-1:0];

  // Result and write-back for the request in its execute cycle.
  always_comb begin
    rsp_next    = '0;
    ram_wr      = 1'b0;
    ram_wr_addr = stat.first_free;
    ram_wr_data = '0;
    map_req     = '0;
    seq_next    = seq_counter;
    case (cur.req_type)
      REQ_ALLOC: begin
        if (!stat.any_free) begin
          rsp_next.status = ST_OUT_OF_HNDL;
        end else begin
          rsp_next.slot = stat.first_free;
          if (cur.use_given_id) begin
            rsp_next.out_node  = cur.id_node;
            rsp_next.out_seq   = cur.id_seq;
            rsp_next.out_local = cur.id_local;
          end else begin
            rsp_next.out_node  = own_node;
            rsp_next.out_local = LOCAL_W'(stat.first_free);
            if (cur.new_seq_wanted) begin
              rsp_next.out_seq = seq_counter;
              seq_next         = seq_counter + SEQ_W'(1);
            end
          end
          ram_wr      = 1'b1;
          ram_wr_data = {rsp_next.out_node, rsp_next.out_seq};
          map_req     = '{we: 1'b1, set: 1'b1, idx: stat.first_free};
        end
      end
      REQ_FIND: begin
        if (find_in_range && used[find_idx] && (rd_node == cur.id_node) &&
            (rd_seq == cur.id_seq)) begin
          rsp_next.slot = find_idx;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      REQ_FREE: begin
        if (!free_in_range) begin
          rsp_next.status = ST_INVALID_SLOT;
        end else begin
          // The stored sequence number is cleared even for a free slot.
          ram_wr      = 1'b1;
          ram_wr_addr = free_idx;
          map_req     = '{we: 1'b1, set: 1'b0, idx: free_idx};
          if (!used[free_idx]) begin
            rsp_next.status = ST_ALREADY_FREE;
          end
        end
      end
      default: begin
        rsp_next.status = ST_INVALID_SLOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      seq_counter <= '0;
      own_node    <= '0;
    end else begin
      if (cfg_wr_en) begin
        own_node <= cfg_wr_data;
      end
      if (rsp_valid && rsp.ready && !exec_go) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state       <= S_IDLE;
            rsp_valid   <= 1'b1;
            rsp_data    <= rsp_next;
            seq_counter <= seq_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RHT_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC, "accepted request did not execute")
  `RHT_ASSERT_NEXT(a_exec_result, exec_go, rsp.valid && (state == S_IDLE), "executed request gave no result")
  `RHT_ASSERT_NOW(a_idle_no_write, state == S_IDLE, !upd.we && !(ram_wr && exec_go), "write-back while idle")

endmodule

`default_nettype wire

/* src/rht_ram.sv */
`default_nettype none

module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/rht_map.sv */
`default_nettype none
`include "rpc_handle_table_assert.svh"

module rht_map import rht_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire map_upd_t             upd,
  output logic      [NUM_SLOTS-1:0] used,
  output map_stat_t                 stat
);

  // First level of the search: per group, a free flag and the lowest free lane.
  logic              grp_free      [GROUPS];
  logic [LANE_W-1:0] grp_idx       [GROUPS];
  logic              grp_free_next [GROUPS];
  logic [LANE_W-1:0] grp_idx_next  [GROUPS];

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_free_next[g] = ~&used[g*LANES +: LANES];
      grp_idx_next[g]  = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
        if (!used[g*LANES + i]) begin
          grp_idx_next[g] = LANE_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        grp_free[g] <= 1'b1;
        grp_idx[g]  <= '0;
      end
    end else begin
      if (upd.we) begin
        used[upd.idx] <= upd.set;
      end
      for (int g = 0; g < GROUPS; g++) begin
        grp_free[g] <= grp_free_next[g];
        grp_idx[g]  <= grp_idx_next[g];
      end
    end
  end

  // Second level: lowest group that has a free lane.
  always_comb begin
    stat.any_free   = 1'b0;
    stat.first_free = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        stat.any_free   = 1'b1;
        stat.first_free = {GROUP_W'(g), grp_idx[g]};
      end
    end
  end

  `RHT_ASSERT_NEXT(a_set_marks, upd.we && upd.set, used[$past(upd.idx)], "set did not mark slot")
  `RHT_ASSERT_NOW(a_first_is_free, $past(!upd.we) && stat.any_free, !used[stat.first_free], "search returned a used slot")

endmodule

`default_nettype wire

/* dv/rpc_handle_table_test.sv */
`timescale 1ns / 100ps

// Testbench for the RPC handle table.
// Requests go in on one valid/ready channel and every request returns exactly
// one result on the other, in order. A behavioral copy of the table runs
// alongside the block. It is updated at the clock edge where a request is
// accepted, and its answer is queued until the block's result comes out.

module rpc_handle_table_test import rht_pkg::*; ();

  // Request type 3 has no meaning and must be answered as an invalid slot.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Generous cycle budget.
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [NODE_W-1:0] cfg_wr_data;

  rht_req_if req_ch ();
  rht_rsp_if rsp_ch ();

  rpc_handle_table u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // Shadow copy of the handle table. The used bits, stored ids and sequence
  // counter mirror what the block should hold after every accepted request.
  bit [NUM_SLOTS-1:0] slot_busy;
  bit [NUM_SLOTS-1:0] slot_written;
  bit [NODE_W-1:0]    stored_node [NUM_SLOTS];
  bit [SEQ_W-1:0]     stored_seq  [NUM_SLOTS];
  bit [SEQ_W-1:0]     seq_next;
  bit [NODE_W-1:0]    node_cfg;

  // Results that the block still owes us, oldest first.
  rsp_t results_due [$];

  int mismatches;
  int requests_sent;
  int results_seen;
  int status_seen [8];
  int cycle_cnt;

  // Idle rates of the two sides, in percent, and a one-shot receiver stall.
  int req_idle_pct;
  int rsp_idle_pct;
  int rsp_hold_req;
  int rsp_hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Work out what the table answers to one request and apply its side
  // effects to the shadow state. The lowest free slot wins an allocation.
  function automatic rsp_t predict_handle_op(input req_t r);
    rsp_t res;
    int s;
    res = '0;
    s = -1;
    case (r.req_type)
      REQ_ALLOC: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (s < 0 && !slot_busy[i]) s = i;
        end
        if (s < 0) begin
          // Table full: nothing changes, the sequence counter included.
          res.status = ST_OUT_OF_HNDL;
        end else begin
          slot_busy[s] = 1'b1;
          slot_written[s] = 1'b1;
          if (r.use_given_id) begin
            res.out_node  = r.id_node;
            res.out_seq   = r.id_seq;
            res.out_local = r.id_local;
          end else begin
            // A locally built id carries our node number and the slot index.
            // The sequence number is either fresh from the counter or zero.
            res.out_node = node_cfg;
            if (r.new_seq_wanted) begin
              res.out_seq = seq_next;
              seq_next = seq_next + 1'b1;
            end
            res.out_local = LOCAL_W'(s);
          end
          stored_node[s] = res.out_node;
          stored_seq[s]  = res.out_seq;
          res.slot       = SLOT_W'(s);
        end
      end
      REQ_FIND: begin
        if (r.id_local >= NUM_SLOTS) begin
          res.status = ST_NOT_FOUND;
        end else begin
          s = int'(r.id_local);
          if (!slot_busy[s] || stored_node[s] != r.id_node || stored_seq[s] != r.id_seq)
            res.status = ST_NOT_FOUND;
          else
            res.slot = SLOT_W'(s);
        end
      end
      REQ_FREE: begin
        if (r.free_slot >= NUM_SLOTS) begin
          res.status = ST_INVALID_SLOT;
        end else begin
          // The stored sequence number is cleared even when the slot was
          // already free.
          s = int'(r.free_slot);
          stored_seq[s] = '0;
          if (!slot_busy[s]) res.status = ST_ALREADY_FREE;
          slot_busy[s] = 1'b0;
        end
      end
      default: begin
        res.status = ST_INVALID_SLOT;
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard. Both channels are sampled at the clock edge, before the
  // block or the drivers move anything. The result is checked before the
  // new request is queued; a result can never belong to a request that is
  // accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        status_seen[rsp_ch.data.status]++;
        if (results_due.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, actual %p",
                   $time, rsp_ch.data);
          mismatches++;
        end else begin
          check_field("status", 32'(results_due[0].status), 32'(rsp_ch.data.status));
          check_field("slot", 32'(results_due[0].slot), 32'(rsp_ch.data.slot));
          check_field("out_node", 32'(results_due[0].out_node), 32'(rsp_ch.data.out_node));
          check_field("out_seq", results_due[0].out_seq, rsp_ch.data.out_seq);
          check_field("out_local", 32'(results_due[0].out_local),
                      32'(rsp_ch.data.out_local));
          void'(results_due.pop_front());
        end
      end
      if (req_ch.valid && req_ch.ready)
        results_due.push_back(predict_handle_op(req_ch.data));
    end
  end

  // Result receiver. It drops ready at random, and it can be told to hold
  // off for a long stretch so that the block backs up into its input.
  always @(posedge clk) begin
    if (rsp_hold_req > 0) begin
      rsp_hold_left = rsp_hold_req;
      rsp_hold_req  = 0;
    end
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold_left--;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Offer one request and return at the edge where it is taken. Ready is
  // looked at on the falling edge, where it already holds the value that
  // the next rising edge samples. The task is always entered on a rising
  // edge, and valid gets only one assignment per edge.
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(negedge clk); while (!req_ch.ready);
    @(posedge clk);
    requests_sent++;
  endtask

  // Stop sending and wait until every result owed has come back and the block
  // is idle before anything else.
  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_own_node(input logic [NODE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_cfg = value;
  endtask

  function automatic req_t make_req(input logic [1:0] kind, input logic given,
                                    input logic fresh, input logic [NODE_W-1:0] node,
                                    input logic [SEQ_W-1:0] seq,
                                    input logic [LOCAL_W-1:0] loc,
                                    input logic [LOCAL_W-1:0] fslot);
    req_t r;
    r.req_type       = kind;
    r.use_given_id   = given;
    r.new_seq_wanted = fresh;
    r.id_node        = node;
    r.id_seq         = seq;
    r.id_local       = loc;
    r.free_slot      = fslot;
    return r;
  endfunction

  // Build a request that mostly follows a sensible life cycle: allocate,
  // look the handle up with its real id (or a slightly wrong one), release
  // it. The rest is random noise, including the unknown request type.
  // A find never lands on a slot whose entry was never written.
  function automatic req_t random_request();
    req_t r;
    int pick;
    int alloc_w;
    int start;
    int hit;
    r.req_type       = REQ_ALLOC;
    r.use_given_id   = 1'($urandom_range(1));
    r.new_seq_wanted = 1'($urandom_range(1));
    r.id_node        = NODE_W'($urandom);
    r.id_seq         = $urandom;
    r.id_local       = LOCAL_W'($urandom);
    r.free_slot      = LOCAL_W'($urandom);
    // Keep the table from sitting full: allocate less once it is crowded.
    alloc_w = ($countones(slot_busy) < 40) ? 40 : 15;
    pick    = $urandom_range(99);
    start   = $urandom_range(NUM_SLOTS - 1);
    hit     = -1;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (hit < 0 && slot_busy[(start + k) % NUM_SLOTS]) hit = (start + k) % NUM_SLOTS;
    end
    if (pick < alloc_w || hit < 0) begin
      if ($urandom_range(7) == 0) r.id_seq = $urandom_range(1) ? '1 : '0;
    end else if (pick < alloc_w + 25) begin
      r.req_type = REQ_FIND;
      r.id_local = LOCAL_W'(hit);
      r.id_node  = stored_node[hit];
      r.id_seq   = stored_seq[hit];
      // About a third of the lookups carry one wrong bit in the id.
      if (pick >= alloc_w + 17) begin
        if ($urandom_range(1))
          r.id_node[$urandom_range(NODE_W - 1)] ^= 1'b1;
        else
          r.id_seq[$urandom_range(SEQ_W - 1)] ^= 1'b1;
      end
    end else if (pick < alloc_w + 45) begin
      r.req_type  = REQ_FREE;
      r.free_slot = LOCAL_W'(hit);
    end else if (pick < alloc_w + 50) begin
      r.req_type  = REQ_FREE;
      r.free_slot = LOCAL_W'($urandom_range(1) ? $urandom_range(NUM_SLOTS - 1)
                                               : $urandom_range(65535));
    end else begin
      r.req_type = 2'($urandom_range(3));
    end
    if (r.req_type == REQ_FIND && r.id_local < NUM_SLOTS && !slot_written[r.id_local])
      r.id_local[SLOT_W] = 1'b1;
    return r;
  endfunction

  // Hand-picked requests: range errors on both find and free, the unknown
  // request type, local ids with and without a fresh sequence number,
  // supplied ids at both extremes, lookups that hit and that miss on node or
  // sequence, double release, lookup of a released slot and reuse of the
  // lowest free slot. The table is left empty.
  task automatic test_directed_ops();
    req_idle_pct = 20;
    rsp_idle_pct = 20;
    send_request(make_req(REQ_FIND, 1'b0, 1'b0, 8'h00, 32'h0, 16'hFFFF, 16'h0));
    send_request(make_req(REQ_FREE, 1'b0, 1'b0, 8'h00, 32'h0, 16'h0, 16'hFFFF));
    send_request(make_req(REQ_FREE, 1'b0, 1'b0, 8'h00, 32'h0, 16'h0, 16'(NUM_SLOTS)));
    send_request(make_req(REQ_UNKNOWN, 1'b1, 1'b1, 8'hFF, '1, 16'hFFFF, 16'h0001));
    send_request(make_req(REQ_ALLOC, 1'b0, 1'b0, 8'h5A, 32'h1234, 16'h0, 16'h0));
    send_request(make_req(REQ_ALLOC, 1'b0, 1'b1, 8'h00, 32'h0, 16'h0, 16'h0));
    send_request(make_req(REQ_ALLOC, 1'b0, 1'b1, 8'h00, 32'h0, 16'h0, 16'h0));
    send_request(make_req(REQ_ALLOC, 1'b1, 1'b0, 8'hFF, '1, 16'hFFFF, 16'hFFFF));
    send_request(make_req(REQ_ALLOC, 1'b1, 1'b1, 8'h00, 32'h0, 16'h0, 16'h0));
    send_request(make_req(REQ_FIND, 1'b0, 1'b0, 8'hFF, '1, 16'd3, 16'h0));
    send_request(make_req(REQ_FIND, 1'b0, 1'b0, 8'hFE, '1, 16'd3, 16'h0));
    send_request(make_req(REQ_FIND, 1'b0, 1'b0, 8'hFF, 32'hFFFF_FFFE, 16'd3, 16'h0));
    send_request(make_req(REQ_FIND, 1'b0, 1'b0, 8'h00, 32'h0, 16'(NUM_SLOTS), 16'h0));
    send_request(make_req(REQ_FIND, 1'b0, 1'b0, 8'h00, 32'h1, 16'd2, 16'h0));
    send_request(make_req(REQ_FREE, 1'b0, 1'b0, 8'h00, 32'h0, 16'h0, 16'd1));
    send_request(make_req(REQ_FREE, 1'b0, 1'b0, 8'h00, 32'h0, 16'h0, 16'd1));
    send_request(make_req(REQ_FIND, 1'b0, 1'b0, 8'h00, 32'h0, 16'd1, 16'h0));
    send_request(make_req(REQ_ALLOC, 1'b0, 1'b1, 8'h00, 32'h0, 16'h0, 16'h0));
    send_request(make_req(REQ_FREE, 1'b0, 1'b0, 8'h00, 32'h0, 16'h0, 16'(NUM_SLOTS - 1)));
    for (int i = 0; i < 5; i++)
      send_request(make_req(REQ_FREE, 1'b0, 1'b0, 8'h00, 32'h0, 16'h0, 16'(i)));
    wait_all_results();
  endtask

  // Allocate past the table size so that the last few report out of
  // handles, then release every slot in a scrambled order.
  task automatic test_table_full();
    req_t r;
    for (int i = 0; i < NUM_SLOTS + 6; i++) begin
      r = random_request();
      r.req_type = REQ_ALLOC;
      send_request(r);
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      r = random_request();
      r.req_type  = REQ_FREE;
      r.free_slot = LOCAL_W'((i * 37) % NUM_SLOTS);
      send_request(r);
    end
    wait_all_results();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // requests back to back, so the block fills up and holds off its input.
  task automatic test_backpressure();
    req_idle_pct = 0;
    rsp_idle_pct = 20;
    rsp_hold_req = 150;
    for (int i = 0; i < 24; i++)
      send_request(random_request());
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    req_idle_pct = idle_pct;
    rsp_idle_pct = idle_pct;
    for (int i = 0; i < count; i++)
      send_request(random_request());
    wait_all_results();
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.data   <= '0;
    mismatches    = 0;
    requests_sent = 0;
    results_seen  = 0;
    rsp_hold_req  = 0;
    rsp_hold_left = 0;
    req_idle_pct  = 20;
    rsp_idle_pct  = 20;
    slot_busy     = '0;
    slot_written  = '0;
    seq_next      = '0;
    node_cfg      = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // The directed part runs with the node number left at its reset value.
    test_directed_ops();
    write_own_node(8'hFF);
    test_table_full();
    write_own_node(NODE_W'($urandom));
    test_backpressure();
    write_own_node(8'h00);
    test_random_traffic(100, 20);
    // This phase is the long stretch where neither side ever idles.
    write_own_node(NODE_W'($urandom));
    test_random_traffic(100, 0);
    write_own_node(8'h01);
    test_random_traffic(100, 20);

    repeat (20) @(posedge clk);
    $display("Run covered %0d requests and %0d results over %0d cycles.",
             requests_sent, results_seen, cycle_cnt);
    $display("Status counts: ok %0d, out of handles %0d, not found %0d, invalid %0d, %s %0d.",
             status_seen[ST_OK], status_seen[ST_OUT_OF_HNDL], status_seen[ST_NOT_FOUND],
             status_seen[ST_INVALID_SLOT], "already free", status_seen[ST_ALREADY_FREE]);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
